// ----- rtl/binary_trie_max_xor_top_assert.svh -----
// assertion macros for the binary trie max-xor block
// depends on nothing; included by the top level only
`ifndef BINARY_TRIE_MAX_XOR_TOP_ASSERT_SVH
`define BINARY_TRIE_MAX_XOR_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BTMX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define BTMX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/btmx_pkg.sv -----
// shared constants, types and microcode table of the binary trie max-xor block
// depends on nothing
`timescale 1ns / 1ps

package btmx_pkg;

	localparam int KEY_BITS   = 32;
	localparam int NODE_COUNT = 4096;

	localparam int VALUE_W = 32;
	localparam int NODE_W  = $clog2(NODE_COUNT);
	localparam int CNT_W   = NODE_W + 1;
	localparam int ENTRY_W = 2 * NODE_W;
	localparam int LVL_W   = $clog2(KEY_BITS);

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// operation kinds
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	// microprogram steps
	localparam int STEP_W = 2;
	localparam logic [STEP_W-1:0] STEP_IDLE     = 2'd0;
	localparam logic [STEP_W-1:0] STEP_DISPATCH = 2'd1;
	localparam logic [STEP_W-1:0] STEP_WALK     = 2'd2;
	localparam logic [STEP_W-1:0] STEP_RESPOND  = 2'd3;

	// jump conditions
	localparam int COND_W = 2;
	localparam logic [COND_W-1:0] COND_ACCEPT   = 2'd0;
	localparam logic [COND_W-1:0] COND_RUN_WALK = 2'd1;
	localparam logic [COND_W-1:0] COND_LAST     = 2'd2;
	localparam logic [COND_W-1:0] COND_OUT_FREE = 2'd3;

	typedef struct packed {
		logic capture;
		logic dispatch;
		logic walk;
		logic respond;
	} ctl_t;

	typedef struct packed {
		ctl_t              ctl;
		logic [COND_W-1:0] cond;
		logic [STEP_W-1:0] tgt_true;
		logic [STEP_W-1:0] tgt_false;
	} ucode_t;

	typedef struct packed {
		logic accept;
		logic run_walk;
		logic last_level;
		logic out_free;
	} cond_t;

	// control store: one word per step
	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		w = '0;
		case (step)
			STEP_IDLE: begin
				w.ctl.capture = 1'b1;
				w.cond        = COND_ACCEPT;
				w.tgt_true    = STEP_DISPATCH;
				w.tgt_false   = STEP_IDLE;
			end
			STEP_DISPATCH: begin
				w.ctl.dispatch = 1'b1;
				w.cond         = COND_RUN_WALK;
				w.tgt_true     = STEP_WALK;
				w.tgt_false    = STEP_RESPOND;
			end
			STEP_WALK: begin
				w.ctl.walk = 1'b1;
				w.cond     = COND_LAST;
				w.tgt_true = STEP_RESPOND;
				w.tgt_false = STEP_WALK;
			end
			STEP_RESPOND: begin
				w.ctl.respond = 1'b1;
				w.cond        = COND_OUT_FREE;
				w.tgt_true    = STEP_IDLE;
				w.tgt_false   = STEP_RESPOND;
			end
			default: begin
				w.tgt_true  = STEP_IDLE;
				w.tgt_false = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/binary_trie_max_xor_top.sv -----
// top level of the binary trie max-xor block: handshakes, result register
// depends on btmx_pkg, btmx_seq, btmx_datapath, binary_trie_max_xor_top_assert.svh
`timescale 1ns / 1ps
//
//  channel | signals                         | direction | moves
//  --------+---------------------------------+-----------+---------------------------
//  input   | in_valid, in_stall, kind, value | in        | one insert or query request
//  output  | out_valid, out_stall, best_xor, | out       | one result per request
//          | status                          |           |
//
//  a request runs from acceptance to result through one dispatch step, one walk step for each
//  of the KEY_BITS trie levels (one trie level a cycle, set by the node memory read latency) and
//  one respond step that loads the result register; requests that skip the walk go straight
//  from dispatch to respond; one request is worked at a time;
//  in_stall is high except in the idle step
//  out_stall holds the result register and keeps the sequencer in its respond step
//  reset clears the root links, the allocator and the has-keys flag at once;
//  no clearing pass over node memory: a node allocated by an insert reads as empty via the fresh flag

`include "binary_trie_max_xor_top_assert.svh"

module binary_trie_max_xor_top import btmx_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic [VALUE_W-1:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [VALUE_W-1:0] best_xor,
	output logic [1:0]         status
);

	ctl_t               ctl;
	cond_t              cond;
	logic               in_accept;
	logic               out_free;
	logic [VALUE_W-1:0] dp_best;
	logic [1:0]         dp_status;
	logic               dp_run_walk;
	logic               dp_last;
	logic               out_valid_q;
	logic [VALUE_W-1:0] best_xor_q;
	logic [1:0]         status_q;

	// requests are taken only in the idle step
	assign in_stall  = !ctl.capture;
	assign in_accept = in_valid && !in_stall;

	// result register can take a new result when empty or being drained
	assign out_free = !out_valid_q || !out_stall;

	assign cond.accept     = in_accept;
	assign cond.run_walk   = dp_run_walk;
	assign cond.last_level = dp_last;
	assign cond.out_free   = out_free;

	btmx_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cond   (cond),
		.ctl    (ctl)
	);

	btmx_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.load       (in_accept),
		.kind_in    (kind),
		.value_in   (value),
		.best       (dp_best),
		.status     (dp_status),
		.run_walk   (dp_run_walk),
		.last_level (dp_last)
	);

	// result register: valid in reset domain, payload plain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.respond && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.respond && out_free) begin
			best_xor_q <= dp_best;
			status_q   <= dp_status;
		end
	end

	assign out_valid = out_valid_q;
	assign best_xor  = best_xor_q;
	assign status    = status_q;

	// an accepted request always moves the sequencer to dispatch
	`BTMX_ASSERT_NEXT(a_accept_dispatch, clk, arst_n, in_accept, ctl.dispatch, "no dispatch after accept")

	// a new result only appears out of the respond step
	`BTMX_ASSERT_NOW(a_result_from_respond, clk, arst_n, $rose(out_valid_q), $past(ctl.respond), "result without respond step")

	// failed requests carry a zero answer
	`BTMX_ASSERT_NOW(a_fail_zero, clk, arst_n, out_valid_q && (status_q != ST_OK), best_xor_q == '0, "nonzero answer on failed request")

endmodule

// ----- rtl/btmx_seq.sv -----
// microcode sequencer: step counter, control store lookup, conditional jumps
// depends on btmx_pkg
`timescale 1ns / 1ps

module btmx_seq import btmx_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cond_t cond,
	output ctl_t  ctl
);

	logic [STEP_W-1:0] step_q;
	ucode_t            uw;
	logic              take;

	assign uw  = ucode_rom(step_q);
	assign ctl = uw.ctl;

	always_comb begin
		case (uw.cond)
			COND_ACCEPT:   take = cond.accept;
			COND_RUN_WALK: take = cond.run_walk;
			COND_LAST:     take = cond.last_level;
			COND_OUT_FREE: take = cond.out_free;
			default:       take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= take ? uw.tgt_true : uw.tgt_false;
		end
	end

endmodule

// ----- rtl/btmx_datapath.sv -----
// trie datapath: node memory, root links, walk registers, allocator
// depends on btmx_pkg
`timescale 1ns / 1ps

module btmx_datapath import btmx_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  ctl_t                ctl,
	input  logic                load,
	input  logic                kind_in,
	input  logic [VALUE_W-1:0]  value_in,
	output logic [VALUE_W-1:0]  best,
	output logic [1:0]          status,
	output logic                run_walk,
	output logic                last_level
);

	// node 0 lives in flops, the rest in memory
	logic [ENTRY_W-1:0] mem [NODE_COUNT];
	logic [ENTRY_W-1:0] rd_q;
	logic [ENTRY_W-1:0] root_q;

	logic [CNT_W-1:0]    next_free_q;
	logic                has_keys_q;
	logic                fresh_q;
	logic                kind_q;
	logic [KEY_BITS-1:0] key_q;
	logic [KEY_BITS-1:0] best_q;
	logic [NODE_W-1:0]   node_q;
	logic [LVL_W-1:0]    lvl_q;
	logic [1:0]          status_q;

	logic               full;
	logic [ENTRY_W-1:0] entry;
	logic               bit_b;
	logic [NODE_W-1:0]  link_b;
	logic [NODE_W-1:0]  link_o;
	logic               take_opp;
	logic               alloc;
	logic [NODE_W-1:0]  nx;
	logic [ENTRY_W-1:0] new_entry;
	logic               wr_en;

	assign full = next_free_q > CNT_W'(NODE_COUNT - KEY_BITS);
	assign run_walk = (kind_q == KIND_QUERY) ? has_keys_q : !full;
	assign last_level = (lvl_q == '0);

	assign entry  = fresh_q ? '0 : ((node_q == '0) ? root_q : rd_q);
	assign bit_b  = key_q[lvl_q];
	assign link_b = bit_b ? entry[ENTRY_W-1:NODE_W] : entry[NODE_W-1:0];
	assign link_o = bit_b ? entry[NODE_W-1:0] : entry[ENTRY_W-1:NODE_W];

	assign take_opp = (link_o != '0);
	assign alloc    = (link_b == '0);

	always_comb begin
		if (kind_q == KIND_QUERY) begin
			nx = take_opp ? link_o : link_b;
		end else begin
			nx = alloc ? next_free_q[NODE_W-1:0] : link_b;
		end
	end

	assign new_entry = bit_b ? {nx, link_o} : {link_o, nx};
	assign wr_en     = ctl.walk && (kind_q == KIND_INSERT) && alloc;

	// memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en && (node_q != '0)) begin
			mem[node_q] <= new_entry;
		end
		rd_q <= mem[nx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q      <= '0;
			next_free_q <= CNT_W'(1);
			has_keys_q  <= 1'b0;
			fresh_q     <= 1'b0;
		end else begin
			if (ctl.dispatch) begin
				fresh_q <= 1'b0;
				if ((kind_q == KIND_INSERT) && !full) begin
					has_keys_q <= 1'b1;
				end
			end
			if (wr_en) begin
				next_free_q <= next_free_q + CNT_W'(1);
				fresh_q     <= 1'b1;
				if (node_q == '0) begin
					root_q <= new_entry;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= kind_in;
			key_q  <= KEY_BITS'(value_in);
		end
		if (ctl.dispatch) begin
			node_q <= '0;
			lvl_q  <= LVL_W'(KEY_BITS - 1);
			best_q <= '0;
			if (kind_q == KIND_QUERY) begin
				status_q <= has_keys_q ? ST_OK : ST_EMPTY;
			end else begin
				status_q <= full ? ST_FULL : ST_OK;
			end
		end
		if (ctl.walk) begin
			node_q <= nx;
			lvl_q  <= lvl_q - LVL_W'(1);
			if ((kind_q == KIND_QUERY) && take_opp) begin
				best_q <= best_q | (KEY_BITS'(1) << lvl_q);
			end
		end
	end

	assign best   = VALUE_W'(best_q);
	assign status = status_q;

endmodule
